FILE: rtl/vvpd_pkg.sv
// shared types, constants and helpers for the vehicle video packet deframer
// no dependencies
package vvpd_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned POS_W    = 5;
    localparam int unsigned LEN_W    = 16;
    localparam int unsigned SIM_W    = 48;
    localparam int unsigned TS_W     = 64;

    localparam logic [POS_W-1:0] COMMON_LEN    = 5'd16;
    localparam logic [POS_W-1:0] VIDEO_HDR_LEN = 5'd14;
    localparam logic [POS_W-1:0] AUDIO_HDR_LEN = 5'd10;
    localparam logic [POS_W-1:0] PASS_HDR_LEN  = 5'd2;
    localparam logic [POS_W-1:0] TS_BYTES      = 5'd8;

    localparam logic [POS_W-1:0] POS_PT_MARKER = 5'd5;
    localparam logic [POS_W-1:0] POS_SEQ_HI    = 5'd6;
    localparam logic [POS_W-1:0] POS_SEQ_LO    = 5'd7;
    localparam logic [POS_W-1:0] POS_SIM_FIRST = 5'd8;
    localparam logic [POS_W-1:0] POS_SIM_LAST  = 5'd13;
    localparam logic [POS_W-1:0] POS_CHANNEL   = 5'd14;

    localparam logic [3:0] TYPE_VIDEO_MAX = 4'd2;
    localparam logic [3:0] TYPE_AUDIO     = 4'd3;
    localparam logic [3:0] TYPE_MAX       = 4'd4;

    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_ERROR   = 2'd2
    } result_kind_t;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
    } byte_item_t;

    function automatic logic [POS_W-1:0] type_hdr_len(input logic [3:0] ptype);
        logic [POS_W-1:0] len;
        if (ptype <= TYPE_VIDEO_MAX)
        begin
            len = VIDEO_HDR_LEN;
        end
        else if (ptype == TYPE_AUDIO)
        begin
            len = AUDIO_HDR_LEN;
        end
        else
        begin
            len = PASS_HDR_LEN;
        end
        return len;
    endfunction

endpackage

FILE: rtl/vehicle_video_packet_deframer_top.sv
// path: each byte is held in the input register, then its result in the parser result register
// throughput: one byte per cycle, with a result stall held by the input register
// reset: rst_n clears the parser to wait for a common header and empties both registers
// top level of the vehicle video packet deframer
// depends on vvpd_pkg, vvpd_in_reg, vvpd_parser
module vehicle_video_packet_deframer_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  result_kind,
    output logic [15:0] sequence_number,
    output logic [3:0]  packet_type,
    output logic [1:0]  fragment_mark,
    output logic [7:0]  channel_number,
    output logic [6:0]  payload_type,
    output logic        marker_bit,
    output logic [47:0] sim_number,
    output logic [63:0] time_stamp,
    output logic [15:0] data_length,
    output logic [7:0]  payload_byte,
    output logic        last_byte
);
    import vvpd_pkg::*;

    byte_item_t item;
    logic       advance;

    vvpd_in_reg u_in_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .data_byte (data_byte),
        .advance   (advance),
        .item      (item)
    );

    vvpd_parser u_parser (
        .clk             (clk),
        .rst_n           (rst_n),
        .item            (item),
        .advance         (advance),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .result_kind     (result_kind),
        .sequence_number (sequence_number),
        .packet_type     (packet_type),
        .fragment_mark   (fragment_mark),
        .channel_number  (channel_number),
        .payload_type    (payload_type),
        .marker_bit      (marker_bit),
        .sim_number      (sim_number),
        .time_stamp      (time_stamp),
        .data_length     (data_length),
        .payload_byte    (payload_byte),
        .last_byte       (last_byte)
    );

endmodule

FILE: rtl/vvpd_in_reg.sv
// input register for the stream bytes
// depends on vvpd_pkg
module vvpd_in_reg (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [7:0]                data_byte,
    input  logic                      advance,
    output vvpd_pkg::byte_item_t      item
);
    import vvpd_pkg::*;

    logic              valid_reg;
    logic [BYTE_W-1:0] data_reg;

    // held item blocks a new one until the parser takes it
    assign in_stall = valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            data_reg <= data_byte;
        end
    end

    assign item.valid = valid_reg;
    assign item.data  = data_reg;

endmodule

FILE: rtl/vvpd_parser.sv
// packet parser state and result register
// depends on vvpd_pkg
module vvpd_parser (
    input  logic                  clk,
    input  logic                  rst_n,
    input  vvpd_pkg::byte_item_t  item,
    output logic                  advance,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [1:0]            result_kind,
    output logic [15:0]           sequence_number,
    output logic [3:0]            packet_type,
    output logic [1:0]            fragment_mark,
    output logic [7:0]            channel_number,
    output logic [6:0]            payload_type,
    output logic                  marker_bit,
    output logic [47:0]           sim_number,
    output logic [63:0]           time_stamp,
    output logic [15:0]           data_length,
    output logic [7:0]            payload_byte,
    output logic                  last_byte
);
    import vvpd_pkg::*;

    typedef enum logic [1:0] {
        PH_COMMON  = 2'd0,
        PH_TYPEHDR = 2'd1,
        PH_PAYLOAD = 2'd2
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [LEN_W-1:0]  rem_reg, rem_next;
    logic [15:0]       seq_reg, seq_next;
    logic [SIM_W-1:0]  sim_reg, sim_next;
    logic [7:0]        chan_reg, chan_next;
    logic [7:0]        tam_reg, tam_next;
    logic [7:0]        ptm_reg, ptm_next;
    logic [TS_W-1:0]   ts_reg, ts_next;

    logic              out_valid_reg;
    result_kind_t      kind_reg;
    logic [15:0]       seq_out_reg;
    logic [7:0]        tam_out_reg;
    logic [7:0]        chan_out_reg;
    logic [7:0]        ptm_out_reg;
    logic [SIM_W-1:0]  sim_out_reg;
    logic [TS_W-1:0]   ts_out_reg;
    logic [LEN_W-1:0]  len_out_reg;
    logic [7:0]        pay_out_reg;
    logic              last_out_reg;

    logic              take;
    logic              emit;
    result_kind_t      kind_c;
    logic [TS_W-1:0]   ts_c;
    logic [LEN_W-1:0]  len_c;
    logic [7:0]        pay_c;
    logic              last_c;
    logic [3:0]        cur_type;
    logic [POS_W-1:0]  hdr_len;
    logic [POS_W-1:0]  pos_inc;
    logic [7:0]        b;

    assign advance  = !out_valid_reg || !out_stall;
    assign take     = item.valid && advance;
    assign b        = item.data;
    assign cur_type = tam_reg[7:4];
    assign hdr_len  = type_hdr_len(cur_type);
    assign pos_inc  = pos_reg + 5'd1;

    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        rem_next   = rem_reg;
        seq_next   = seq_reg;
        sim_next   = sim_reg;
        chan_next  = chan_reg;
        tam_next   = tam_reg;
        ptm_next   = ptm_reg;
        ts_next    = ts_reg;
        emit       = 1'b0;
        kind_c     = KIND_HEADER;
        ts_c       = ts_reg;
        len_c      = '0;
        pay_c      = '0;
        last_c     = 1'b0;
        if (take)
        begin
            case (phase_reg)
                PH_TYPEHDR:
                begin
                    if (cur_type <= TYPE_AUDIO && pos_reg < TS_BYTES)
                    begin
                        ts_next = {ts_reg[TS_W-9:0], b};
                    end
                    if (pos_reg >= hdr_len - 5'd2)
                    begin
                        rem_next = {rem_reg[7:0], b};
                    end
                    if (pos_inc >= hdr_len)
                    begin
                        emit     = 1'b1;
                        kind_c   = KIND_HEADER;
                        ts_c     = ts_next;
                        len_c    = rem_next;
                        last_c   = (rem_next == '0);
                        pos_next = '0;
                        phase_next = (rem_next == '0) ? PH_COMMON : PH_PAYLOAD;
                    end
                    else
                    begin
                        pos_next = pos_inc;
                    end
                end
                PH_PAYLOAD:
                begin
                    rem_next = rem_reg - 16'd1;
                    emit     = 1'b1;
                    kind_c   = KIND_PAYLOAD;
                    pay_c    = b;
                    last_c   = (rem_next == '0);
                    if (rem_next == '0)
                    begin
                        phase_next = PH_COMMON;
                        pos_next   = '0;
                    end
                end
                default:
                begin
                    phase_next = PH_COMMON;
                    pos_next   = pos_inc;
                    if (pos_reg == POS_PT_MARKER)
                    begin
                        ptm_next = b;
                    end
                    else if (pos_reg == POS_SEQ_HI || pos_reg == POS_SEQ_LO)
                    begin
                        seq_next = {seq_reg[7:0], b};
                    end
                    else if (pos_reg inside {[POS_SIM_FIRST:POS_SIM_LAST]})
                    begin
                        sim_next = {sim_reg[SIM_W-9:0], b};
                    end
                    else if (pos_reg == POS_CHANNEL)
                    begin
                        chan_next = b;
                    end
                    else if (pos_reg >= COMMON_LEN - 5'd1)
                    begin
                        tam_next = b;
                        pos_next = '0;
                        if (b[7:4] > TYPE_MAX)
                        begin
                            emit   = 1'b1;
                            kind_c = KIND_ERROR;
                            ts_c   = '0;
                            last_c = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_TYPEHDR;
                            ts_next    = '0;
                            rem_next   = '0;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_COMMON;
            pos_reg       <= '0;
            rem_reg       <= '0;
            seq_reg       <= '0;
            sim_reg       <= '0;
            chan_reg      <= '0;
            tam_reg       <= '0;
            ptm_reg       <= '0;
            ts_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            rem_reg   <= rem_next;
            seq_reg   <= seq_next;
            sim_reg   <= sim_next;
            chan_reg  <= chan_next;
            tam_reg   <= tam_next;
            ptm_reg   <= ptm_next;
            ts_reg    <= ts_next;
            if (advance)
            begin
                out_valid_reg <= emit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            kind_reg     <= kind_c;
            seq_out_reg  <= seq_next;
            tam_out_reg  <= tam_next;
            chan_out_reg <= chan_next;
            ptm_out_reg  <= ptm_next;
            sim_out_reg  <= sim_next;
            ts_out_reg   <= ts_c;
            len_out_reg  <= len_c;
            pay_out_reg  <= pay_c;
            last_out_reg <= last_c;
        end
    end

    assign out_valid       = out_valid_reg;
    assign result_kind     = kind_reg;
    assign sequence_number = seq_out_reg;
    assign packet_type     = tam_out_reg[7:4];
    assign fragment_mark   = tam_out_reg[1:0];
    assign channel_number  = chan_out_reg;
    assign payload_type    = ptm_out_reg[6:0];
    assign marker_bit      = ptm_out_reg[7];
    assign sim_number      = sim_out_reg;
    assign time_stamp      = ts_out_reg;
    assign data_length     = len_out_reg;
    assign payload_byte    = pay_out_reg;
    assign last_byte       = last_out_reg;

    a_payload_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PAYLOAD |-> rem_reg != '0)
        else $error("payload phase with no bytes remaining");

    a_typehdr_pos: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_TYPEHDR |-> pos_reg < VIDEO_HDR_LEN && cur_type <= TYPE_MAX)
        else $error("type header position or type out of range");

    a_common_pos: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_COMMON |-> pos_reg < COMMON_LEN)
        else $error("common header position out of range");

    a_error_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && kind_reg == KIND_ERROR |-> last_out_reg && ts_out_reg == '0)
        else $error("error item not marked last");

    a_payload_after_type: assert property (@(posedge clk) disable iff (!rst_n)
        take && phase_reg == PH_PAYLOAD |=> phase_reg == PH_PAYLOAD || phase_reg == PH_COMMON)
        else $error("payload phase left to type header");

endmodule

FILE: tb/vehicle_video_packet_deframer_top_test.sv
// self-checking testbench for vehicle_video_packet_deframer_top: byte stream in, parsed results out
// holds its own deframer predictor in a scoreboard class; depends on vvpd_pkg and the rtl
`timescale 1ns / 1ps

module vehicle_video_packet_deframer_top_test;
    import vvpd_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int RANDOM_BYTES = 400;
    localparam int HOLD_CYCLES = 400;

    typedef enum logic [1:0] {
        PH_WAIT_COMMON = 2'd0,
        PH_TYPE_HEADER = 2'd1,
        PH_PAYLOAD     = 2'd2
    } parse_phase_t;

    typedef struct {
        result_kind_t kind;
        logic [15:0]  seq;
        logic [3:0]   ptype;
        logic [1:0]   frag;
        logic [7:0]   chan;
        logic [6:0]   pt;
        logic         marker;
        logic [47:0]  sim;
        logic [63:0]  ts;
        logic [15:0]  len;
        logic [7:0]   pay;
        logic         last_flag;
    } deframer_result_t;

    class packet_scoreboard;
        deframer_result_t pending[$];
        int errors = 0;
        parse_phase_t phase = PH_WAIT_COMMON;
        logic [4:0]  hpos = '0;
        logic [15:0] remaining = '0;
        logic [15:0] seq = '0;
        logic [47:0] sim = '0;
        logic [7:0]  chan = '0;
        logic [7:0]  type_mark = '0;
        logic [7:0]  ptm = '0;
        logic [63:0] ts = '0;

        function logic [4:0] hdr_len();
            logic [3:0] ty;
            ty = type_mark[7:4];
            if (ty <= TYPE_VIDEO_MAX)
            begin
                return VIDEO_HDR_LEN;
            end
            else if (ty == TYPE_AUDIO)
            begin
                return AUDIO_HDR_LEN;
            end
            return PASS_HDR_LEN;
        endfunction

        function bit at_length_high();
            return phase == PH_TYPE_HEADER && hpos == hdr_len() - 5'd2;
        endfunction

        function deframer_result_t make_result(result_kind_t kind, logic [63:0] ts_v,
                                               logic [15:0] len_v, logic [7:0] pay_v,
                                               logic last_v);
            deframer_result_t r;
            r.kind = kind;
            r.seq = seq;
            r.ptype = type_mark[7:4];
            r.frag = type_mark[1:0];
            r.chan = chan;
            r.pt = ptm[6:0];
            r.marker = ptm[7];
            r.sim = sim;
            r.ts = ts_v;
            r.len = len_v;
            r.pay = pay_v;
            r.last_flag = last_v;
            return r;
        endfunction

        function void note_input(logic [7:0] b);
            logic [4:0] hl;
            logic [4:0] pos;
            logic done;
            case (phase)
                PH_TYPE_HEADER:
                begin
                    hl = hdr_len();
                    pos = hpos;
                    if (type_mark[7:4] <= TYPE_AUDIO && pos < TS_BYTES)
                    begin
                        ts = {ts[55:0], b};
                    end
                    if (pos >= hl - 5'd2)
                    begin
                        remaining = {remaining[7:0], b};
                    end
                    pos = pos + 5'd1;
                    if (pos >= hl)
                    begin
                        done = (remaining == 16'd0);
                        pending.insert(pending.size(),
                                       make_result(KIND_HEADER, ts, remaining, 8'd0, done));
                        hpos = '0;
                        phase = done ? PH_WAIT_COMMON : PH_PAYLOAD;
                    end
                    else
                    begin
                        hpos = pos;
                    end
                end
                PH_PAYLOAD:
                begin
                    remaining = remaining - 16'd1;
                    done = (remaining == 16'd0);
                    pending.insert(pending.size(),
                                   make_result(KIND_PAYLOAD, ts, 16'd0, b, done));
                    if (done)
                    begin
                        phase = PH_WAIT_COMMON;
                        hpos = '0;
                    end
                end
                default:
                begin
                    pos = hpos;
                    if (pos == POS_PT_MARKER)
                    begin
                        ptm = b;
                    end
                    else if (pos == POS_SEQ_HI || pos == POS_SEQ_LO)
                    begin
                        seq = {seq[7:0], b};
                    end
                    else if (pos >= POS_SIM_FIRST && pos <= POS_SIM_LAST)
                    begin
                        sim = {sim[39:0], b};
                    end
                    else if (pos == POS_CHANNEL)
                    begin
                        chan = b;
                    end
                    if (pos >= COMMON_LEN - 5'd1)
                    begin
                        type_mark = b;
                        hpos = '0;
                        if (b[7:4] > TYPE_MAX)
                        begin
                            phase = PH_WAIT_COMMON;
                            pending.insert(pending.size(),
                                           make_result(KIND_ERROR, 64'd0, 16'd0, 8'd0, 1'b1));
                        end
                        else
                        begin
                            phase = PH_TYPE_HEADER;
                            ts = '0;
                            remaining = '0;
                        end
                    end
                    else
                    begin
                        hpos = pos + 5'd1;
                        phase = PH_WAIT_COMMON;
                    end
                end
            endcase
        endfunction

        task report_mismatch(string msg);
            if (errors < 30)
            begin
                $display("[%0t] mismatch: %s", $realtime, msg);
            end
            errors++;
        endtask

        task compare_field(string name, logic [63:0] got, logic [63:0] want);
            if (got !== want)
            begin
                report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
            end
        endtask

        task check_result(deframer_result_t got);
            deframer_result_t want;
            if (pending.size() == 0)
            begin
                report_mismatch("result with no item pending");
                return;
            end
            want = pending.pop_front();
            compare_field("result_kind", got.kind, want.kind);
            compare_field("sequence_number", got.seq, want.seq);
            compare_field("packet_type", got.ptype, want.ptype);
            compare_field("fragment_mark", got.frag, want.frag);
            compare_field("channel_number", got.chan, want.chan);
            compare_field("payload_type", got.pt, want.pt);
            compare_field("marker_bit", got.marker, want.marker);
            compare_field("sim_number", got.sim, want.sim);
            compare_field("time_stamp", got.ts, want.ts);
            compare_field("data_length", got.len, want.len);
            compare_field("payload_byte", got.pay, want.pay);
            compare_field("last_byte", got.last_flag, want.last_flag);
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  data_byte;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  result_kind;
    logic [15:0] sequence_number;
    logic [3:0]  packet_type;
    logic [1:0]  fragment_mark;
    logic [7:0]  channel_number;
    logic [6:0]  payload_type;
    logic        marker_bit;
    logic [47:0] sim_number;
    logic [63:0] time_stamp;
    logic [15:0] data_length;
    logic [7:0]  payload_byte;
    logic        last_byte;

    packet_scoreboard sb = new;
    int  bytes_sent = 0;
    int  cycle_count = 0;
    bit  burst = 1'b0;
    bit  hold_req = 1'b0;

    vehicle_video_packet_deframer_top dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .data_byte(data_byte),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .result_kind(result_kind),
        .sequence_number(sequence_number),
        .packet_type(packet_type),
        .fragment_mark(fragment_mark),
        .channel_number(channel_number),
        .payload_type(payload_type),
        .marker_bit(marker_bit),
        .sim_number(sim_number),
        .time_stamp(time_stamp),
        .data_length(data_length),
        .payload_byte(payload_byte),
        .last_byte(last_byte)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function int sender_gap();
        int r;
        r = $urandom_range(0, 99);
        if (burst || r < 65)
        begin
            return 0;
        end
        if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(5, 40);
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = sender_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_input(b);
        bytes_sent++;
    endtask

    task automatic send_packet(input logic [3:0] ptype, input logic [3:0] frag,
                               input logic [15:0] len, input bit fixed, input logic [7:0] fill);
        logic [7:0] pkt[$];
        int extra;
        repeat (15) pkt.insert(pkt.size(), fixed ? fill : 8'($urandom));
        pkt.insert(pkt.size(), {ptype, frag});
        if (ptype <= TYPE_MAX)
        begin
            extra = (ptype <= TYPE_VIDEO_MAX) ? 12 : (ptype == TYPE_AUDIO) ? 8 : 0;
            repeat (extra) pkt.insert(pkt.size(), fixed ? fill : 8'($urandom));
            pkt.insert(pkt.size(), len[15:8]);
            pkt.insert(pkt.size(), len[7:0]);
            repeat (int'(len)) pkt.insert(pkt.size(), fixed ? fill : 8'($urandom));
        end
        foreach (pkt[i])
        begin
            send_byte(pkt[i]);
        end
    endtask

    task automatic send_noise(input int count);
        logic [7:0] b;
        repeat (count)
        begin
            b = sb.at_length_high() ? 8'h00 : 8'($urandom);
            send_byte(b);
        end
        while (!(sb.phase == PH_WAIT_COMMON && sb.hpos == 5'd0))
        begin
            b = sb.at_length_high() ? 8'h00 : 8'($urandom);
            send_byte(b);
        end
    endtask

    initial
    begin
        int start_count;
        int pick;
        logic [15:0] len;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        data_byte <= 8'h00;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed packets: field extremes, every valid type, empty payloads, bad types, then noise and a long burst
        send_packet(4'd0, 4'h0, 16'd0, 1'b1, 8'h00);
        send_packet(4'd1, 4'hf, 16'd3, 1'b1, 8'hff);
        send_packet(4'd2, 4'h1, 16'd2, 1'b0, 8'h00);
        send_packet(TYPE_AUDIO, 4'h2, 16'd4, 1'b0, 8'h00);
        send_packet(TYPE_MAX, 4'h3, 16'd0, 1'b0, 8'h00);
        send_packet(TYPE_MAX, 4'h7, 16'd5, 1'b1, 8'hff);
        send_packet(4'd5, 4'hf, 16'd0, 1'b1, 8'hff);
        send_packet(4'd15, 4'h0, 16'd0, 1'b0, 8'h00);
        send_packet(TYPE_AUDIO, 4'h0, 16'd0, 1'b1, 8'h00);
        send_noise(7);
        burst = 1'b1;
        send_packet(4'd0, 4'h0, 16'h0100, 1'b0, 8'h00);
        burst = 1'b0;

        hold_req = 1'b1;
        start_count = bytes_sent;
        while (bytes_sent < start_count + RANDOM_BYTES)
        begin
            burst = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 75)
            begin
                case ($urandom_range(0, 19))
                    0: len = 16'($urandom_range(41, 300));
                    1, 2, 3, 4, 5: len = 16'($urandom_range(9, 40));
                    default: len = 16'($urandom_range(0, 8));
                endcase
                send_packet(4'($urandom_range(0, 4)), 4'($urandom), len, 1'b0, 8'h00);
            end
            else if (pick < 87)
            begin
                send_packet(4'($urandom_range(5, 15)), 4'($urandom), 16'd0, 1'b0, 8'h00);
            end
            else
            begin
                send_noise($urandom_range(1, 20));
            end
        end
        in_valid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (sb.errors == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial
    begin
        deframer_result_t got;
        int hold_left;
        int stall_left;
        int mode;
        int mode_left;
        bit hold_done;
        bit next_stall;
        int r;
        hold_left = 0;
        stall_left = 0;
        mode = 0;
        mode_left = 0;
        hold_done = 1'b0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                got.kind = result_kind_t'(result_kind);
                got.seq = sequence_number;
                got.ptype = packet_type;
                got.frag = fragment_mark;
                got.chan = channel_number;
                got.pt = payload_type;
                got.marker = marker_bit;
                got.sim = sim_number;
                got.ts = time_stamp;
                got.len = data_length;
                got.pay = payload_byte;
                got.last_flag = last_byte;
                sb.check_result(got);
            end
            next_stall = 1'b0;
            if (hold_left > 0)
            begin
                hold_left--;
                next_stall = 1'b1;
            end
            else if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                next_stall = 1'b1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode = $urandom_range(0, 2);
                    mode_left = $urandom_range(50, 400);
                end
                mode_left--;
                r = $urandom_range(0, 99);
                if (stall_left > 0)
                begin
                    stall_left--;
                    next_stall = 1'b1;
                end
                else if (mode == 1 && r < 20)
                begin
                    stall_left = $urandom_range(0, 2);
                    next_stall = 1'b1;
                end
                else if (mode == 2 && r < 40)
                begin
                    stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 3)
                                                               : $urandom_range(10, 40);
                    next_stall = 1'b1;
                end
            end
            out_stall <= next_stall;
        end
    end

endmodule

FILE: sim.f
rtl/vvpd_pkg.sv
rtl/vvpd_in_reg.sv
rtl/vvpd_parser.sv
rtl/vehicle_video_packet_deframer_top.sv
tb/vehicle_video_packet_deframer_top_test.sv
